// File: rtl/scaled_decimal_to_text_core_defines.svh
// Assertion macros shared by the scaled decimal to text core.
`ifndef SCALED_DECIMAL_TO_TEXT_CORE_DEFINES_SVH
`define SCALED_DECIMAL_TO_TEXT_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define SDT_ASSERT_IMPL(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked out of reset.
`define SDT_ASSERT_NEXT(label, ck, rst_n, ante, cons, msg) \
	label: assert property (@(posedge ck) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/sdt_pkg.sv
`default_nettype none
package sdt_pkg;

	// Input request: unscaled two's complement value and its scale
	typedef struct packed {
		logic [63:0]        unscaled_low;
		logic signed [63:0] unscaled_high;
		logic [7:0]         scale;
	} sdt_in_t;

	// One output character
	typedef struct packed {
		logic [6:0] char_code;
		logic       last_char;
		logic       scale_error;
	} sdt_out_t;

	// Classification handed from front to back
	typedef struct packed {
		logic       err;
		logic       neg;
		logic [7:0] scale;
	} sdt_cls_t;

	// Back end sequencer
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_LEAD,
		ST_INT,
		ST_POINT,
		ST_FRAC,
		ST_ERR
	} sdt_state_t;

	localparam int unsigned DIGIT_W    = 4;
	localparam int unsigned QUEUE_DEPTH = 2;

	localparam logic [6:0] CHAR_ZERO  = 7'h30;
	localparam logic [6:0] CHAR_NINE  = 7'h39;
	localparam logic [6:0] CHAR_POINT = 7'h2E;
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [6:0] CHAR_NONE  = 7'h00;

	localparam logic [3:0] BCD_LIMIT  = 4'd5;
	localparam logic [3:0] BCD_ADJUST = 4'd3;

endpackage
`default_nettype wire

// File: rtl/sdt_front.sv
`default_nettype none
module sdt_front #(
	parameter int unsigned VALUE_BITS = 128,
	parameter int unsigned MAX_SCALE  = 38
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   data_valid,
	output logic                  data_ready,
	input  sdt_pkg::sdt_in_t      data,
	output logic                  q_valid,
	input  wire                   q_pop,
	output sdt_pkg::sdt_cls_t     q_cls,
	output logic [VALUE_BITS-1:0] q_mag
);
	import sdt_pkg::*;

	logic [127:0]          raw;
	logic [VALUE_BITS-1:0] val;
	logic [VALUE_BITS-1:0] mag;
	sdt_cls_t              cls;
	logic                  push;

	logic [VALUE_BITS-1:0] mag_q [QUEUE_DEPTH];
	sdt_cls_t              cls_q [QUEUE_DEPTH];
	logic                  wr_ptr_q;
	logic                  rd_ptr_q;
	logic [1:0]            count_q;

	// Classify: treat the low VALUE_BITS bits as signed, take the magnitude, check the scale
	assign raw       = {data.unscaled_high, data.unscaled_low};
	assign val       = raw[VALUE_BITS-1:0];
	assign cls.neg   = val[VALUE_BITS-1];
	assign cls.err   = (data.scale > 8'(MAX_SCALE));
	assign cls.scale = data.scale;
	assign mag       = cls.neg ? (~val + {{(VALUE_BITS-1){1'b0}}, 1'b1}) : val;

	// Two-entry queue toward the back end
	assign data_ready = (count_q != 2'(QUEUE_DEPTH));
	assign push       = data_valid && data_ready;
	assign q_valid    = (count_q != 2'd0);
	assign q_cls      = cls_q[rd_ptr_q];
	assign q_mag      = mag_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (q_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (push && !q_pop)
				count_q <= count_q + 2'd1;
			else if (!push && q_pop)
				count_q <= count_q - 2'd1;
		end
	end

	// Queue storage, no reset needed
	always_ff @(posedge clk) begin
		if (push) begin
			mag_q[wr_ptr_q] <= mag;
			cls_q[wr_ptr_q] <= cls;
		end
	end

endmodule
`default_nettype wire

// File: rtl/sdt_back.sv
`default_nettype none
module sdt_back #(
	parameter int unsigned VALUE_BITS = 128,
	parameter int unsigned MAX_SCALE  = 38
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   q_valid,
	output logic                  q_pop,
	input  sdt_pkg::sdt_cls_t     q_cls,
	input  wire [VALUE_BITS-1:0]  q_mag,
	output logic                  char_valid,
	input  wire                   char_ready,
	output sdt_pkg::sdt_out_t     char_data
);
	import sdt_pkg::*;

	// Digits needed for the magnitude, and for zero padding up to the scale
	localparam int unsigned NDIG = (VALUE_BITS * 30103) / 100000 + 1;
	localparam int unsigned DB   = (NDIG > MAX_SCALE + 1) ? NDIG : MAX_SCALE + 1;
	localparam int unsigned BW   = DB * DIGIT_W;
	localparam int unsigned PW   = $clog2(DB);
	localparam int unsigned CW   = $clog2(VALUE_BITS);

	sdt_state_t            state_q, state_d;
	logic [BW-1:0]         bcd_q, bcd_d;
	logic [VALUE_BITS-1:0] sh_q, sh_d;
	logic [CW-1:0]         cnt_q, cnt_d;
	logic [PW-1:0]         p_q, p_d;
	sdt_cls_t              cls_q, cls_d;
	logic                  ov_q, ov_d;
	sdt_out_t              od_q, od_d;

	logic [BW-1:0]         bcd_adj;
	logic [BW-1:0]         bcd_shl1;
	logic [BW-1:0]         bcd_shl4;
	logic [3:0]            top;
	logic                  rest_zero;
	logic [7:0]            p_ext;
	logic                  p_gt;
	logic                  p_eq;
	logic                  emit_ok;
	logic [6:0]            digit_char;
	logic                  last;

	// Add-3 correction on every digit, then shift in the next binary bit
	always_comb begin
		for (int i = 0; i < DB; i++) begin
			if (bcd_q[i*DIGIT_W +: DIGIT_W] >= BCD_LIMIT)
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W] + BCD_ADJUST;
			else
				bcd_adj[i*DIGIT_W +: DIGIT_W] = bcd_q[i*DIGIT_W +: DIGIT_W];
		end
	end

	assign bcd_shl1   = {bcd_adj[BW-2:0], sh_q[VALUE_BITS-1]};
	assign bcd_shl4   = {bcd_q[BW-DIGIT_W-1:0], {DIGIT_W{1'b0}}};
	assign top        = bcd_q[BW-1 -: DIGIT_W];
	assign rest_zero  = ~|bcd_q[BW-DIGIT_W-1:0];
	assign p_ext      = {{(8-PW){1'b0}}, p_q};
	assign p_gt       = (p_ext > cls_q.scale);
	assign p_eq       = (p_ext == cls_q.scale);
	assign emit_ok    = !ov_q || char_ready;
	assign digit_char = CHAR_ZERO + {3'b000, top};

	assign char_valid = ov_q;
	assign char_data  = od_q;

	// Sequencer: conversion, leading zero skip, character emission, error result
	always_comb begin
		state_d = state_q;
		bcd_d   = bcd_q;
		sh_d    = sh_q;
		cnt_d   = cnt_q;
		p_d     = p_q;
		cls_d   = cls_q;
		ov_d    = ov_q && !char_ready;
		od_d    = od_q;
		q_pop   = 1'b0;
		last    = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					q_pop   = 1'b1;
					cls_d   = q_cls;
					sh_d    = q_mag;
					bcd_d   = '0;
					cnt_d   = '0;
					state_d = q_cls.err ? ST_ERR : ST_CONV;
				end
			end
			ST_CONV: begin
				bcd_d = bcd_shl1;
				sh_d  = {sh_q[VALUE_BITS-2:0], 1'b0};
				cnt_d = cnt_q + 1'b1;
				if (cnt_q == CW'(VALUE_BITS - 1)) begin
					p_d     = PW'(DB - 1);
					state_d = cls_q.neg ? ST_SIGN : ST_LEAD;
				end
			end
			ST_SIGN: begin
				if (emit_ok) begin
					ov_d    = 1'b1;
					od_d    = '{char_code: CHAR_MINUS, last_char: 1'b0, scale_error: 1'b0};
					state_d = ST_LEAD;
				end
			end
			ST_LEAD: begin
				if (top == 4'd0 && p_gt) begin
					bcd_d = bcd_shl4;
					p_d   = p_q - 1'b1;
				end else begin
					state_d = ST_INT;
				end
			end
			ST_INT: begin
				if (emit_ok) begin
					last  = p_eq && rest_zero;
					ov_d  = 1'b1;
					od_d  = '{char_code: digit_char, last_char: last, scale_error: 1'b0};
					bcd_d = bcd_shl4;
					p_d   = p_q - 1'b1;
					if (p_eq)
						state_d = last ? ST_IDLE : ST_POINT;
				end
			end
			ST_POINT: begin
				if (emit_ok) begin
					ov_d    = 1'b1;
					od_d    = '{char_code: CHAR_POINT, last_char: 1'b0, scale_error: 1'b0};
					state_d = ST_FRAC;
				end
			end
			ST_FRAC: begin
				if (emit_ok) begin
					ov_d  = 1'b1;
					od_d  = '{char_code: digit_char, last_char: rest_zero, scale_error: 1'b0};
					bcd_d = bcd_shl4;
					p_d   = p_q - 1'b1;
					if (rest_zero)
						state_d = ST_IDLE;
				end
			end
			ST_ERR: begin
				if (emit_ok) begin
					ov_d    = 1'b1;
					od_d    = '{char_code: CHAR_NONE, last_char: 1'b1, scale_error: 1'b1};
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ov_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			ov_q    <= ov_d;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		bcd_q <= bcd_d;
		sh_q  <= sh_d;
		cnt_q <= cnt_d;
		p_q   <= p_d;
		cls_q <= cls_d;
		od_q  <= od_d;
	end

endmodule
`default_nettype wire

// File: rtl/scaled_decimal_to_text_core.sv
`default_nettype none
// Scaled decimal to text.
// Input channel (data_valid/data_ready/data): one request carries a signed
// unscaled value as two 64-bit halves plus a scale. Output channel
// (char_valid/char_ready/char_data): one ASCII character per transfer,
// last_char set on the final one. A scale above MAX_SCALE yields a single
// transfer with scale_error set and char_code zero.
// A front stage classifies each request (sign, magnitude, scale check) into
// a two-entry queue; the back stage converts and emits on its own pace.
// Per request the back stage loads the entry, runs bit-serial double dabble
// over VALUE_BITS bits, emits the sign if negative, skips leading zero
// digit positions from the top down to the scale, then emits the integer
// digits, the point and fraction digits up to the last nonzero one, if any.
// An error request is loaded and then emits its single transfer. The back
// stage pops the next entry only after it has issued the last character
// of the current one. A stalled receiver holds the output register and
// freezes emission; the queue keeps accepting until both entries are full.
// Reset (arst_n low) empties the queue and drops any request in flight.
module scaled_decimal_to_text_core #(
	parameter int unsigned VALUE_BITS = 128,
	parameter int unsigned MAX_SCALE  = 38
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                data_valid,
	output logic               data_ready,
	input  sdt_pkg::sdt_in_t   data,
	output logic               char_valid,
	input  wire                char_ready,
	output sdt_pkg::sdt_out_t  char_data
);
	import sdt_pkg::*;

	logic                  q_valid;
	logic                  q_pop;
	sdt_cls_t              q_cls;
	logic [VALUE_BITS-1:0] q_mag;

	sdt_front #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_SCALE  (MAX_SCALE)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data       (data),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_cls      (q_cls),
		.q_mag      (q_mag)
	);

	sdt_back #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_SCALE  (MAX_SCALE)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_cls      (q_cls),
		.q_mag      (q_mag),
		.char_valid (char_valid),
		.char_ready (char_ready),
		.char_data  (char_data)
	);

	`include "scaled_decimal_to_text_core_defines.svh"

	// Back end never pops an empty queue
	`SDT_ASSERT_IMPL(a_pop_nonempty, clk, arst_n, q_pop, q_valid, "pop from empty queue")
	// Back end never pops twice in a row
	`SDT_ASSERT_NEXT(a_pop_spacing, clk, arst_n, q_pop, !q_pop, "back-to-back pops")
	// Error result is a final, zero character
	`SDT_ASSERT_IMPL(a_err_form, clk, arst_n, char_valid && char_data.scale_error,
		char_data.last_char && (char_data.char_code == CHAR_NONE), "malformed error result")
	// Normal characters are digits, minus or point
	`SDT_ASSERT_IMPL(a_char_set, clk, arst_n, char_valid && !char_data.scale_error,
		((char_data.char_code >= CHAR_ZERO) && (char_data.char_code <= CHAR_NINE)) ||
		(char_data.char_code == CHAR_MINUS) || (char_data.char_code == CHAR_POINT),
		"bad character code")

endmodule
`default_nettype wire

// File: tb/sdt_text_checker.sv
// Watches both channels of the scaled decimal to text core, predicts the
// character stream of every accepted request and compares it in order.
module sdt_text_checker #(
	parameter int unsigned VALUE_BITS = 128,
	parameter int unsigned MAX_SCALE  = 38
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               data_valid,
	input  logic               data_ready,
	input  sdt_pkg::sdt_in_t   data,
	input  logic               char_valid,
	input  logic               char_ready,
	input  sdt_pkg::sdt_out_t  char_data,
	output int                 mismatch_count,
	output int                 chars_outstanding,
	output int                 values_seen,
	output int                 scale_errors_seen,
	output int                 chars_checked
);
	import sdt_pkg::*;

	sdt_out_t expected_chars[$];
	int       fails;
	int       n_values;
	int       n_overflow;
	int       n_chars;

	function automatic sdt_out_t make_char(logic [6:0] code, logic last, logic err);
		sdt_out_t c;
		c.char_code   = code;
		c.last_char   = last;
		c.scale_error = err;
		return c;
	endfunction

	// Append the text of one request to the expected character stream
	function automatic void predict_text(sdt_in_t req);
		logic [127:0] raw;
		logic [127:0] mag;
		logic         neg;
		logic [6:0]   rev_digits[48];
		int           sh;
		int           sc;
		int           n;
		int           int_len;
		int           frac_len;
		int           total;
		int           idx;
		sc = req.scale;
		if (sc > MAX_SCALE) begin
			expected_chars.push_back(make_char(CHAR_NONE, 1'b1, 1'b1));
			n_overflow++;
			return;
		end
		// keep the low VALUE_BITS bits, sign-extended
		raw = {req.unscaled_high, req.unscaled_low};
		sh  = 128 - VALUE_BITS;
		raw = $signed(raw << sh) >>> sh;
		neg = raw[127];
		mag = neg ? -raw : raw;
		// decimal digits, least significant first
		n = 0;
		do begin
			rev_digits[n] = CHAR_ZERO + 7'(mag % 10);
			mag = mag / 10;
			n++;
		end while (mag != 0);
		// pad so the integer part keeps at least one digit
		while (n <= sc) begin
			rev_digits[n] = CHAR_ZERO;
			n++;
		end
		int_len  = n - sc;
		frac_len = sc;
		// trailing fraction zeros are dropped
		while (frac_len > 0 && rev_digits[sc - frac_len] == CHAR_ZERO)
			frac_len--;
		total = (neg ? 1 : 0) + int_len + (frac_len > 0 ? 1 + frac_len : 0);
		idx = 0;
		if (neg) begin
			idx++;
			expected_chars.push_back(make_char(CHAR_MINUS, idx == total, 1'b0));
		end
		for (int i = 0; i < int_len; i++) begin
			idx++;
			expected_chars.push_back(make_char(rev_digits[n - 1 - i], idx == total, 1'b0));
		end
		if (frac_len > 0) begin
			idx++;
			expected_chars.push_back(make_char(CHAR_POINT, idx == total, 1'b0));
			for (int i = 0; i < frac_len; i++) begin
				idx++;
				expected_chars.push_back(make_char(rev_digits[n - 1 - int_len - i],
					idx == total, 1'b0));
			end
		end
	endfunction

	// Compare delivered characters, queue up predictions for new requests
	always @(posedge clk or negedge arst_n) begin
		sdt_out_t want;
		if (!arst_n) begin
			expected_chars.delete();
			fails      = 0;
			n_values   = 0;
			n_overflow = 0;
			n_chars    = 0;
		end else begin
			if (char_valid && char_ready) begin
				if (expected_chars.size() == 0) begin
					fails++;
					$display("%0t: unexpected character: expected none, %s %h last %b err %b",
						$time, "got code", char_data.char_code, char_data.last_char,
						char_data.scale_error);
				end else begin
					want = expected_chars.pop_front();
					n_chars++;
					if (char_data.char_code !== want.char_code ||
					    char_data.last_char !== want.last_char ||
					    char_data.scale_error !== want.scale_error) begin
						fails++;
						$display("%0t: character mismatch: expected code %h last %b err %b,",
							$time, want.char_code, want.last_char, want.scale_error);
						$display("%0t:   got code %h last %b err %b",
							$time, char_data.char_code, char_data.last_char,
							char_data.scale_error);
					end
				end
			end
			if (data_valid && data_ready) begin
				n_values++;
				predict_text(data);
			end
		end
		mismatch_count    <= fails;
		chars_outstanding <= expected_chars.size();
		values_seen       <= n_values;
		scale_errors_seen <= n_overflow;
		chars_checked     <= n_chars;
	end

endmodule

// File: tb/scaled_decimal_to_text_core_tb.sv
// Drives requests into the scaled decimal to text core with random pacing;
// the checker next to the block does the prediction and comparison.
module scaled_decimal_to_text_core_tb;
	import sdt_pkg::*;

	localparam int unsigned VALUE_BITS  = 128;
	localparam int unsigned MAX_SCALE   = 38;
	localparam int          N_RANDOM    = 475;
	localparam int          CYCLE_LIMIT = 5_000_000;

	logic      clk;
	logic      arst_n;
	logic      data_valid;
	logic      data_ready;
	sdt_in_t   data;
	logic      char_valid;
	logic      char_ready;
	sdt_out_t  char_data;

	int        mismatch_count;
	int        chars_outstanding;
	int        values_seen;
	int        scale_errors_seen;
	int        chars_checked;
	int        cycles = 0;
	logic      steady;
	logic [127:0] pow10[0:38];

	scaled_decimal_to_text_core #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_SCALE (MAX_SCALE)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.data_valid(data_valid),
		.data_ready(data_ready),
		.data      (data),
		.char_valid(char_valid),
		.char_ready(char_ready),
		.char_data (char_data)
	);

	sdt_text_checker #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_SCALE (MAX_SCALE)
	) u_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.data_valid       (data_valid),
		.data_ready       (data_ready),
		.data             (data),
		.char_valid       (char_valid),
		.char_ready       (char_ready),
		.char_data        (char_data),
		.mismatch_count   (mismatch_count),
		.chars_outstanding(chars_outstanding),
		.values_seen      (values_seen),
		.scale_errors_seen(scale_errors_seen),
		.chars_checked    (chars_checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d characters still expected",
				cycles, chars_outstanding);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Mostly no gap, some short ones, a few long
	function automatic int pick_gap(int hi_long);
		int r;
		r = $urandom_range(0, 99);
		if (steady || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, hi_long);
	endfunction

	// Receiver stalls
	initial begin
		int run;
		logic lvl;
		char_ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (steady) begin
				char_ready <= 1'b1;
				@(posedge clk);
			end else begin
				lvl = ($urandom_range(0, 99) < 60);
				run = lvl ? $urandom_range(1, 20) : pick_gap(40);
				if (run == 0)
					run = 1;
				char_ready <= lvl;
				repeat (run) @(posedge clk);
			end
		end
	end

	// Present one request and hold it until accepted
	task automatic send_num(logic [127:0] v, int sc);
		int gap;
		gap = pick_gap(60);
		if (gap > 0) begin
			data_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		data.unscaled_low  <= v[63:0];
		data.unscaled_high <= v[127:64];
		data.scale         <= 8'(sc);
		data_valid         <= 1'b1;
		@(posedge clk);
		while (!data_ready) @(posedge clk);
	endtask

	// Values of many shapes: full width, any magnitude, near powers of ten
	function automatic logic [127:0] rand_value();
		logic [127:0] v;
		int r;
		int k;
		v = {$urandom, $urandom, $urandom, $urandom};
		r = $urandom_range(0, 9);
		k = $urandom_range(0, 38);
		case (r)
			0: ;
			4: v = pow10[k] + 128'($signed(32'($urandom_range(0, 4)) - 2));
			5: v = pow10[k] * $urandom_range(1, 9);
			6: v = 128'($urandom_range(0, 1));
			default: v = v >> $urandom_range(0, 127);
		endcase
		if ($urandom_range(0, 1))
			v = -v;
		return v;
	endfunction

	function automatic int rand_scale();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return $urandom_range(MAX_SCALE + 1, 255);
		if (r < 20)
			return $urandom_range(0, 1) ? MAX_SCALE : 0;
		return $urandom_range(0, MAX_SCALE);
	endfunction

	initial begin
		logic [127:0] most_neg;
		logic [127:0] most_pos;
		arst_n     = 1'b0;
		data_valid = 1'b0;
		data       = '0;
		steady     = 1'b0;
		pow10[0]   = 128'd1;
		for (int k = 1; k <= 38; k++)
			pow10[k] = pow10[k - 1] * 10;
		most_neg = {1'b1, 127'd0};
		most_pos = {1'b0, {127{1'b1}}};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed: zero, unit values, extremes, padding, trimming, bad scales
		send_num(128'd0, 0);
		send_num(128'd0, MAX_SCALE);
		send_num(128'd1, 0);
		send_num(-128'd1, 0);
		send_num(128'd1, MAX_SCALE);
		send_num(-128'd1, MAX_SCALE);
		send_num(most_pos, 0);
		send_num(most_pos, MAX_SCALE);
		send_num(most_neg, 0);
		send_num(most_neg, MAX_SCALE);
		send_num(128'd12345, 2);
		send_num(128'd1200, 2);
		send_num(128'd1230, 2);
		send_num(128'd5, 3);
		send_num(-128'd50, 2);
		send_num(128'd7, MAX_SCALE + 1);
		send_num(most_neg, 255);
		send_num(-128'd3, 128);
		send_num(pow10[38], 38);
		send_num({64'd0, {64{1'b1}}}, 10);
		send_num({64'd0, 1'b1, 63'd0}, 5);
		send_num({64'd1, 64'd0}, 20);
		send_num(-pow10[38], 37);
		send_num(pow10[38] - 1, 38);
		send_num(-128'd12345, 5);

		// random requests, with one stretch where neither side idles
		for (int i = 0; i < N_RANDOM; i++) begin
			steady <= (i >= 150 && i < 230);
			send_num(rand_value(), rand_scale());
		end
		data_valid <= 1'b0;
		steady     <= 1'b0;

		// let the checker count the last request, drain, then watch for strays
		@(posedge clk);
		while (chars_outstanding != 0) @(posedge clk);
		repeat (VALUE_BITS + 60) @(posedge clk);

		$display("sent %0d values (%0d with an out of range scale), checked %0d characters",
			values_seen, scale_errors_seen, chars_checked);
		$display("covered zero, both extremes, padding, trailing zero removal and stalls");
		if (mismatch_count == 0 && chars_outstanding == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// File: scaled_decimal_to_text_core.f
+incdir+rtl
rtl/sdt_pkg.sv
rtl/sdt_front.sv
rtl/sdt_back.sv
rtl/scaled_decimal_to_text_core.sv
tb/sdt_text_checker.sv
tb/scaled_decimal_to_text_core_tb.sv
